// ----- hw/rtl/lav_pkg.sv -----
// lav_pkg: shared widths, payload types and rounding helpers for the look-at view matrix block
// used by every module under hw/rtl, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lav_pkg;

  localparam int unsigned QW  = 32;           // q16.16 word
  localparam int unsigned FW  = 18;           // unit vector component, +-65536
  localparam int unsigned UW  = FW + 1;       // u component after rounding
  localparam int unsigned VW  = 51;           // vector to normalize
  localparam int unsigned MW  = VW;           // magnitude
  localparam int unsigned SQW = 64;           // square root datapath
  localparam int unsigned DW  = 49;           // divider remainder
  localparam int unsigned QBW = 18;           // quotient bits
  localparam int unsigned PW  = UW + QW;      // product in the matrix unit
  localparam int unsigned AW  = PW + 2;       // accumulator
  localparam int unsigned RW  = AW - 15;      // rounded accumulator

  localparam logic [QW-1:0] ONE_Q = QW'(65536);

  typedef logic signed [QW-1:0] q16_t;
  typedef logic signed [FW-1:0] unit_t;
  typedef logic signed [UW-1:0] cross_t;
  typedef logic signed [VW-1:0] wide_t;

  typedef struct packed {
    q16_t  [2:0] eye;
    q16_t  [2:0] up;
    unit_t [2:0] f;
    logic        ok;
  } side_t;

  typedef struct packed {
    unit_t  [2:0] s;
    cross_t [2:0] u;
    unit_t  [2:0] f;
    q16_t   [2:0] t;
    logic         degenerate;
  } mat_t;

  // q32.32 to q16.16, half away from zero
  function automatic logic signed [RW-1:0] round16(input logic signed [AW-1:0] v);
    logic [AW-1:0] mag;
    logic [RW-1:0] r;
    begin
      mag = v[AW-1] ? AW'(-v) : AW'(v);
      r   = RW'((mag + AW'(32768)) >> 16);
      round16 = v[AW-1] ? -$signed(r) : $signed(r);
    end
  endfunction

  function automatic q16_t sat32(input logic signed [RW-1:0] v);
    begin
      if (v > $signed(RW'(33'h0_7fff_ffff))) begin
        sat32 = q16_t'(32'h7fff_ffff);
      end else if (v < -$signed(RW'(33'h0_8000_0000))) begin
        sat32 = q16_t'(32'h8000_0000);
      end else begin
        sat32 = q16_t'(v);
      end
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lav_norm.sv -----
// lav_norm: three-stage vector normalizer (scale and square sum, square root, divide)
// depends on lav_pkg
`timescale 1ns / 1ps
`default_nettype none

module lav_norm import lav_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire wide_t [2:0] in_vec_i,
  input  wire side_t       in_side_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output unit_t [2:0]      out_vec_o,
  output logic             out_ok_o,
  output side_t            out_side_o
);

  // scale and square-sum stage
  logic                  a_full_q, a_sh_q;
  logic [1:0]            a_sq_q;
  logic [2:0][MW-1:0]    a_m_q;
  logic [MW-1:0]         a_mx_q;
  logic [2:0]            a_neg_q;
  logic                  a_ok_q;
  logic [SQW-1:0]        a_sum_q;
  side_t                 a_side_q;
  logic [2:0][MW-1:0]    a_abs;
  logic [MW-1:0]         a_mx;
  logic [2*30-1:0]       a_prod;
  logic                  a_done, a_take;

  // square root stage
  logic                  b_full_q;
  logic [4:0]            b_cnt_q;
  logic [SQW-1:0]        b_n_q, b_r_q, b_bit_q;
  logic [2:0][29:0]      b_m_q;
  logic [2:0]            b_neg_q;
  logic                  b_ok_q;
  side_t                 b_side_q;
  logic [SQW-1:0]        t0, t1, n1, r1, bit1, n2, r2, bit2;
  logic                  b_done, b_take;

  // divide stage
  logic                  c_full_q;
  logic [3:0]            c_cnt_q;
  logic [2:0][DW-1:0]    c_rem_q;
  logic [2:0][QBW-1:0]   c_q_q;
  logic [DW-1:0]         c_dv_q;
  logic [2:0]            c_neg_q;
  logic                  c_ok_q;
  side_t                 c_side_q;
  logic [2:0][DW-1:0]    rem1, rem2;
  logic [2:0][QBW-1:0]   q1, q2;
  logic [DW-1:0]         dv1, dv2;
  logic [31:0]           len;
  logic                  c_done;

  assign in_ready_o = !a_full_q;
  assign a_done     = a_sh_q && (a_sq_q == 2'd3);
  assign a_take     = a_full_q && a_done && !b_full_q;
  assign b_done     = (b_cnt_q == 5'd16);
  assign b_take     = b_full_q && b_done && !c_full_q;
  assign c_done     = (c_cnt_q == 4'd9);
  assign out_valid_o = c_full_q && c_done;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_abs[i] = in_vec_i[i][VW-1] ? MW'(-in_vec_i[i]) : MW'(in_vec_i[i]);
    end
    a_mx = a_abs[0];
    if (a_abs[1] > a_mx) a_mx = a_abs[1];
    if (a_abs[2] > a_mx) a_mx = a_abs[2];
    a_prod = a_m_q[a_sq_q][29:0] * a_m_q[a_sq_q][29:0];
  end

  always_comb begin
    t0   = b_r_q + b_bit_q;
    n1   = (b_n_q >= t0) ? b_n_q - t0 : b_n_q;
    r1   = (b_n_q >= t0) ? (b_r_q >> 1) + b_bit_q : b_r_q >> 1;
    bit1 = b_bit_q >> 2;
    t1   = r1 + bit1;
    n2   = (n1 >= t1) ? n1 - t1 : n1;
    r2   = (n1 >= t1) ? (r1 >> 1) + bit1 : r1 >> 1;
    bit2 = bit1 >> 2;
    len  = b_r_q[31:0];
  end

  always_comb begin
    dv1 = c_dv_q >> 1;
    dv2 = dv1 >> 1;
    for (int i = 0; i < 3; i++) begin
      rem1[i] = (c_rem_q[i] >= c_dv_q) ? c_rem_q[i] - c_dv_q : c_rem_q[i];
      q1[i]   = {c_q_q[i][QBW-2:0], c_rem_q[i] >= c_dv_q};
      rem2[i] = (rem1[i] >= dv1) ? rem1[i] - dv1 : rem1[i];
      q2[i]   = {q1[i][QBW-2:0], rem1[i] >= dv1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_full_q <= 1'b0;
      b_full_q <= 1'b0;
      c_full_q <= 1'b0;
      a_sh_q   <= 1'b0;
      a_sq_q   <= 2'd0;
      b_cnt_q  <= 5'd0;
      c_cnt_q  <= 4'd0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        a_full_q <= 1'b1;
        a_sh_q   <= 1'b0;
        a_sq_q   <= 2'd0;
      end else if (a_take) begin
        a_full_q <= 1'b0;
      end else if (a_full_q && !a_sh_q) begin
        if (!a_ok_q || (a_mx_q[29] && !(|a_mx_q[MW-1:30]))) a_sh_q <= 1'b1;
      end else if (a_full_q && !a_done) begin
        a_sq_q <= a_sq_q + 2'd1;
      end
      if (a_take) begin
        b_full_q <= 1'b1;
        b_cnt_q  <= 5'd0;
      end else if (b_take) begin
        b_full_q <= 1'b0;
      end else if (b_full_q && !b_done) begin
        b_cnt_q <= b_cnt_q + 5'd1;
      end
      if (b_take) begin
        c_full_q <= 1'b1;
        c_cnt_q  <= 4'd0;
      end else if (out_valid_o && out_ready_i) begin
        c_full_q <= 1'b0;
      end else if (c_full_q && !c_done) begin
        c_cnt_q <= c_cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_m_q    <= a_abs;
      a_mx_q   <= a_mx;
      a_ok_q   <= (a_mx != '0);
      a_sum_q  <= '0;
      a_side_q <= in_side_i;
      for (int i = 0; i < 3; i++) a_neg_q[i] <= in_vec_i[i][VW-1];
    end else if (a_full_q && !a_sh_q && a_ok_q) begin
      if (|a_mx_q[MW-1:37]) begin
        a_mx_q <= a_mx_q >> 8;
        for (int i = 0; i < 3; i++) a_m_q[i] <= a_m_q[i] >> 8;
      end else if (|a_mx_q[MW-1:30]) begin
        a_mx_q <= a_mx_q >> 1;
        for (int i = 0; i < 3; i++) a_m_q[i] <= a_m_q[i] >> 1;
      end else if (!(|a_mx_q[MW-1:21])) begin
        a_mx_q <= a_mx_q << 8;
        for (int i = 0; i < 3; i++) a_m_q[i] <= a_m_q[i] << 8;
      end else if (!(|a_mx_q[MW-1:29])) begin
        a_mx_q <= a_mx_q << 1;
        for (int i = 0; i < 3; i++) a_m_q[i] <= a_m_q[i] << 1;
      end
    end else if (a_full_q && a_sh_q && !a_done) begin
      a_sum_q <= a_sum_q + SQW'(a_prod);
    end

    if (a_take) begin
      b_n_q    <= a_sum_q;
      b_r_q    <= '0;
      b_bit_q  <= SQW'(1) << 62;
      for (int i = 0; i < 3; i++) b_m_q[i] <= a_m_q[i][29:0];
      b_neg_q  <= a_neg_q;
      b_ok_q   <= a_ok_q;
      b_side_q <= a_side_q;
    end else if (b_full_q && !b_done) begin
      b_n_q   <= n2;
      b_r_q   <= r2;
      b_bit_q <= bit2;
    end

    if (b_take) begin
      for (int i = 0; i < 3; i++) begin
        c_rem_q[i] <= DW'({b_m_q[i], 16'h0000}) + DW'(len >> 1);
        c_q_q[i]   <= '0;
      end
      c_dv_q   <= DW'({len, 17'h00000});
      c_neg_q  <= b_neg_q;
      c_ok_q   <= b_ok_q;
      c_side_q <= b_side_q;
    end else if (c_full_q && !c_done) begin
      c_rem_q <= rem2;
      c_q_q   <= q2;
      c_dv_q  <= dv2;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!c_ok_q) begin
        out_vec_o[i] = '0;
      end else if (c_neg_q[i]) begin
        out_vec_o[i] = -$signed(c_q_q[i]);
      end else begin
        out_vec_o[i] = $signed(c_q_q[i]);
      end
    end
  end

  assign out_ok_o   = c_ok_q;
  assign out_side_o = c_side_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lav_cross.sv -----
// lav_cross: cross(f, up) with one shared multiplier, six steps per item
// depends on lav_pkg
`timescale 1ns / 1ps
`default_nettype none

module lav_cross import lav_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire unit_t [2:0] in_f_i,
  input  wire logic        in_ok_i,
  input  wire side_t       in_side_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output wide_t [2:0]      out_vec_o,
  output side_t            out_side_o
);

  logic               full_q;
  logic [2:0]         cnt_q;
  wide_t [2:0]        c_q;
  side_t              side_q;
  logic signed [FW-1:0] op_a;
  logic signed [QW-1:0] op_b;
  logic signed [FW+QW-1:0] prod;
  logic [1:0]         k;
  logic               done;

  assign in_ready_o  = !full_q;
  assign done        = (cnt_q == 3'd6);
  assign out_valid_o = full_q && done;
  assign k           = cnt_q[2:1];

  always_comb begin
    case (cnt_q)
      3'd0: begin op_a = $signed(side_q.f[1]); op_b = $signed(side_q.up[2]); end
      3'd1: begin op_a = $signed(side_q.f[2]); op_b = $signed(side_q.up[1]); end
      3'd2: begin op_a = $signed(side_q.f[2]); op_b = $signed(side_q.up[0]); end
      3'd3: begin op_a = $signed(side_q.f[0]); op_b = $signed(side_q.up[2]); end
      3'd4: begin op_a = $signed(side_q.f[0]); op_b = $signed(side_q.up[1]); end
      3'd5: begin op_a = $signed(side_q.f[1]); op_b = $signed(side_q.up[0]); end
      default: begin op_a = '0; op_b = '0; end
    endcase
    prod = op_a * op_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else if (in_valid_i && in_ready_o) begin
      full_q <= 1'b1;
      cnt_q  <= 3'd0;
    end else if (out_valid_o && out_ready_i) begin
      full_q <= 1'b0;
    end else if (full_q && !done) begin
      cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      side_q.eye <= in_side_i.eye;
      side_q.up  <= in_side_i.up;
      side_q.f   <= in_f_i;
      side_q.ok  <= in_ok_i;
    end else if (full_q && !done) begin
      if (cnt_q[0]) begin
        c_q[k] <= $signed(c_q[k]) - wide_t'(prod);
      end else begin
        c_q[k] <= wide_t'(prod);
      end
    end
  end

  assign out_vec_o  = c_q;
  assign out_side_o = side_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lav_mac.sv -----
// lav_mac: u = cross(s, f) and the three translations on one shared multiply-accumulate
// depends on lav_pkg
`timescale 1ns / 1ps
`default_nettype none

module lav_mac import lav_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire unit_t [2:0] in_s_i,
  input  wire logic        in_ok_i,
  input  wire side_t       in_side_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output mat_t             out_mat_o
);

  logic                    full_q;
  logic [4:0]              cnt_q;
  side_t                   side_q;
  mat_t                    mat_q;
  logic signed [PW-1:0]    prod_q;
  logic signed [AW-1:0]    acc_q, acc_d;
  logic signed [UW-1:0]    op_a;
  logic signed [QW-1:0]    op_b;
  logic [3:0]              j;
  logic                    first, neg, grp_end;
  logic signed [RW-1:0]    rnd;
  logic                    done;

  assign in_ready_o  = !full_q;
  assign done        = (cnt_q == 5'd16);
  assign out_valid_o = full_q && done;
  assign j           = cnt_q[3:0] - 4'd1;

  always_comb begin
    case (cnt_q[3:0])
      4'd0:  begin op_a = $signed(mat_q.s[1]); op_b = $signed(side_q.f[2]); end
      4'd1:  begin op_a = $signed(mat_q.s[2]); op_b = $signed(side_q.f[1]); end
      4'd2:  begin op_a = $signed(mat_q.s[2]); op_b = $signed(side_q.f[0]); end
      4'd3:  begin op_a = $signed(mat_q.s[0]); op_b = $signed(side_q.f[2]); end
      4'd4:  begin op_a = $signed(mat_q.s[0]); op_b = $signed(side_q.f[1]); end
      4'd5:  begin op_a = $signed(mat_q.s[1]); op_b = $signed(side_q.f[0]); end
      4'd6:  begin op_a = $signed(mat_q.s[0]); op_b = $signed(side_q.eye[0]); end
      4'd7:  begin op_a = $signed(mat_q.s[1]); op_b = $signed(side_q.eye[1]); end
      4'd8:  begin op_a = $signed(mat_q.s[2]); op_b = $signed(side_q.eye[2]); end
      4'd9:  begin op_a = $signed(side_q.f[0]); op_b = $signed(side_q.eye[0]); end
      4'd10: begin op_a = $signed(side_q.f[1]); op_b = $signed(side_q.eye[1]); end
      4'd11: begin op_a = $signed(side_q.f[2]); op_b = $signed(side_q.eye[2]); end
      4'd12: begin op_a = $signed(mat_q.u[0]); op_b = $signed(side_q.eye[0]); end
      4'd13: begin op_a = $signed(mat_q.u[1]); op_b = $signed(side_q.eye[1]); end
      4'd14: begin op_a = $signed(mat_q.u[2]); op_b = $signed(side_q.eye[2]); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // step j: accumulate the product registered in the previous cycle
  always_comb begin
    case (j)
      4'd0, 4'd2, 4'd4, 4'd9: begin first = 1'b1; neg = 1'b0; grp_end = 1'b0; end
      4'd6, 4'd12:            begin first = 1'b1; neg = 1'b1; grp_end = 1'b0; end
      4'd1, 4'd3, 4'd5:       begin first = 1'b0; neg = 1'b1; grp_end = 1'b1; end
      4'd7, 4'd13:            begin first = 1'b0; neg = 1'b1; grp_end = 1'b0; end
      4'd8, 4'd14:            begin first = 1'b0; neg = 1'b1; grp_end = 1'b1; end
      4'd10:                  begin first = 1'b0; neg = 1'b0; grp_end = 1'b0; end
      4'd11:                  begin first = 1'b0; neg = 1'b0; grp_end = 1'b1; end
      default:                begin first = 1'b0; neg = 1'b0; grp_end = 1'b0; end
    endcase
    acc_d = (first ? AW'(0) : acc_q) + (neg ? -AW'(prod_q) : AW'(prod_q));
    rnd   = round16(acc_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else if (in_valid_i && in_ready_o) begin
      full_q <= 1'b1;
      cnt_q  <= 5'd0;
    end else if (out_valid_o && out_ready_i) begin
      full_q <= 1'b0;
    end else if (full_q && !done) begin
      cnt_q <= cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      side_q           <= in_side_i;
      mat_q.s          <= in_s_i;
      mat_q.f          <= in_side_i.f;
      mat_q.degenerate <= !(in_ok_i && in_side_i.ok);
    end else if (full_q && !done) begin
      prod_q <= op_a * op_b;
      if (cnt_q != 5'd0) begin
        acc_q <= acc_d;
        if (grp_end) begin
          case (j)
            4'd1:    mat_q.u[0] <= cross_t'(rnd);
            4'd3:    mat_q.u[1] <= cross_t'(rnd);
            4'd5:    mat_q.u[2] <= cross_t'(rnd);
            4'd8:    mat_q.t[0] <= sat32(rnd);
            4'd11:   mat_q.t[2] <= sat32(rnd);
            4'd14:   mat_q.t[1] <= sat32(rnd);
            default: ;
          endcase
        end
      end
    end
  end

  assign out_mat_o = mat_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lav_emit.sv -----
// lav_emit: output register that sends the sixteen matrix elements in column-major order
// depends on lav_pkg
`timescale 1ns / 1ps
`default_nettype none

module lav_emit import lav_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire mat_t  in_mat_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [3:0] out_index_o,
  output q16_t       out_value_o,
  output logic       out_degenerate_o,
  output logic       out_last_o
);

  logic       full_q;
  logic [3:0] idx_q;
  mat_t       mat_q;
  logic       last;

  assign last        = (idx_q == 4'd15);
  assign in_ready_o  = !full_q || (out_ready_i && last);
  assign out_valid_o = full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      idx_q  <= 4'd0;
    end else if (in_valid_i && in_ready_o) begin
      full_q <= 1'b1;
      idx_q  <= 4'd0;
    end else if (full_q && out_ready_i) begin
      if (last) full_q <= 1'b0;
      idx_q <= idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) mat_q <= in_mat_i;
  end

  always_comb begin
    case (idx_q)
      4'd0:    out_value_o = q16_t'($signed(mat_q.s[0]));
      4'd1:    out_value_o = q16_t'($signed(mat_q.u[0]));
      4'd2:    out_value_o = -q16_t'($signed(mat_q.f[0]));
      4'd4:    out_value_o = q16_t'($signed(mat_q.s[1]));
      4'd5:    out_value_o = q16_t'($signed(mat_q.u[1]));
      4'd6:    out_value_o = -q16_t'($signed(mat_q.f[1]));
      4'd8:    out_value_o = q16_t'($signed(mat_q.s[2]));
      4'd9:    out_value_o = q16_t'($signed(mat_q.u[2]));
      4'd10:   out_value_o = -q16_t'($signed(mat_q.f[2]));
      4'd12:   out_value_o = mat_q.t[0];
      4'd13:   out_value_o = mat_q.t[1];
      4'd14:   out_value_o = mat_q.t[2];
      4'd15:   out_value_o = $signed(ONE_Q);
      default: out_value_o = '0;
    endcase
  end

  assign out_index_o      = idx_q;
  assign out_degenerate_o = mat_q.degenerate;
  assign out_last_o       = last;

endmodule

`default_nettype wire

// ----- hw/rtl/look_at_view_matrix.sv -----
// look_at_view_matrix: right-handed look-at view matrix, q16.16 in and out
// depends on lav_pkg, lav_norm, lav_cross, lav_mac, lav_emit
`timescale 1ns / 1ps
`default_nettype none

// Takes eye, target and up in signed q16.16 and sends the 4x4 column-major
// view matrix as sixteen transfers, element 0 first, tlast on element 15 and
// tuser set on all sixteen when target equals eye or up is parallel to the
// view direction (the affected rows are then zero). Work runs through a chain
// of stages: input register, normalize f (scale and square sum, a 2-bit per
// cycle square root, a 2-bit per cycle divider in three lanes), cross product,
// normalize s, a 15-step multiply-accumulate and the output register. Several
// items are in flight at once, one per stage; each stage takes a new item only
// after it has handed on the last, and the output register takes the next
// matrix only as its last transfer is accepted.

module look_at_view_matrix import lav_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  input  wire logic [287:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // element_index [3:0], element_value [35:4], zero fill [39:36]
  output logic [39:0]       m_axis_tdata,
  // degenerate
  output logic              m_axis_tuser,
  output logic              m_axis_tlast
);

  logic        in_full_q;
  wide_t [2:0] d_q;
  side_t       side_q;

  logic        na_rdy, na_vld, cr_rdy, cr_vld, nb_rdy, nb_vld, mc_rdy, mc_vld, em_rdy;
  unit_t [2:0] f_vec, s_vec;
  logic        f_ok, s_ok;
  side_t       na_side, cr_side, nb_side;
  wide_t [2:0] c_vec;
  mat_t        mat;
  logic [3:0]  idx;
  q16_t        value;

  assign s_axis_tready = !in_full_q || na_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full_q <= 1'b1;
    end else if (na_rdy) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= wide_t'($signed(s_axis_tdata[96+32*i +: 32]))
                - wide_t'($signed(s_axis_tdata[32*i +: 32]));
        side_q.eye[i] <= s_axis_tdata[32*i +: 32];
        side_q.up[i]  <= s_axis_tdata[192+32*i +: 32];
        side_q.f[i]   <= '0;
      end
      side_q.ok <= 1'b1;
    end
  end

  lav_norm u_norm_f (
    .clk_i, .rst_ni,
    .in_valid_i  (in_full_q),
    .in_ready_o  (na_rdy),
    .in_vec_i    (d_q),
    .in_side_i   (side_q),
    .out_valid_o (na_vld),
    .out_ready_i (cr_rdy),
    .out_vec_o   (f_vec),
    .out_ok_o    (f_ok),
    .out_side_o  (na_side)
  );

  lav_cross u_cross (
    .clk_i, .rst_ni,
    .in_valid_i  (na_vld),
    .in_ready_o  (cr_rdy),
    .in_f_i      (f_vec),
    .in_ok_i     (f_ok),
    .in_side_i   (na_side),
    .out_valid_o (cr_vld),
    .out_ready_i (nb_rdy),
    .out_vec_o   (c_vec),
    .out_side_o  (cr_side)
  );

  lav_norm u_norm_s (
    .clk_i, .rst_ni,
    .in_valid_i  (cr_vld),
    .in_ready_o  (nb_rdy),
    .in_vec_i    (c_vec),
    .in_side_i   (cr_side),
    .out_valid_o (nb_vld),
    .out_ready_i (mc_rdy),
    .out_vec_o   (s_vec),
    .out_ok_o    (s_ok),
    .out_side_o  (nb_side)
  );

  lav_mac u_mac (
    .clk_i, .rst_ni,
    .in_valid_i  (nb_vld),
    .in_ready_o  (mc_rdy),
    .in_s_i      (s_vec),
    .in_ok_i     (s_ok),
    .in_side_i   (nb_side),
    .out_valid_o (mc_vld),
    .out_ready_i (em_rdy),
    .out_mat_o   (mat)
  );

  lav_emit u_emit (
    .clk_i, .rst_ni,
    .in_valid_i       (mc_vld),
    .in_ready_o       (em_rdy),
    .in_mat_i         (mat),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_index_o      (idx),
    .out_value_o      (value),
    .out_degenerate_o (m_axis_tuser),
    .out_last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {4'h0, value, idx};

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// tb: self-checking testbench for look_at_view_matrix, streams eye/target/up transfers
// and checks each matrix element against an in-bench fixed-point model; depends on lav_pkg
`timescale 1ns / 1ps

module tb;
  import lav_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // element_index [3:0], element_value [35:4], zero fill [39:36]
  logic [39:0]  m_axis_tdata;
  // degenerate
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] value;
    logic        degenerate;
    logic        last;
  } element_t;

  element_t    expected_elements[$];
  int unsigned mismatch_count = 0;
  int unsigned matrices_sent = 0;
  int unsigned elements_seen = 0;
  int unsigned degenerate_seen = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle = 1'b0;
  int unsigned stall_pct = 26;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  look_at_view_matrix u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // returns 0 on zero length
  function automatic bit unit_vector(input longint v[3], output longint r[3]);
    longint unsigned m[3];
    longint unsigned mx, sum, len, q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? longint'(-v[i]) : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      r = '{0, 0, 0};
      return 1'b0;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q    = (m[i] * 64'd65536 + len / 2) / len;
      r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint to_q16(input longint v);
    longint unsigned mag;
    if (v < 0) begin
      mag = -v;
      return -longint'((mag + 64'h8000) >> 16);
    end
    return longint'((longint'(v) + 64'h8000) >> 16);
  endfunction

  function automatic logic [31:0] clamp_q16(input longint v);
    if (v > 64'sh7fff_ffff) return 32'h7fff_ffff;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  task automatic predict_view_matrix(input logic [287:0] item);
    longint eye[3], up[3], d[3], f[3], c[3], s[3], u[3];
    longint val[16];
    bit ok_f, ok_s;
    element_t e;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(item[32*i +: 32]));
      d[i]   = longint'($signed(item[32*(3+i) +: 32])) - eye[i];
      up[i]  = longint'($signed(item[32*(6+i) +: 32]));
    end
    ok_f = unit_vector(d, f);
    c[0] = f[1] * up[2] - f[2] * up[1];
    c[1] = f[2] * up[0] - f[0] * up[2];
    c[2] = f[0] * up[1] - f[1] * up[0];
    ok_s = unit_vector(c, s);
    u[0] = to_q16(s[1] * f[2] - s[2] * f[1]);
    u[1] = to_q16(s[2] * f[0] - s[0] * f[2]);
    u[2] = to_q16(s[0] * f[1] - s[1] * f[0]);
    for (int i = 0; i < 16; i++) val[i] = 0;
    for (int i = 0; i < 3; i++) begin
      val[4*i]     = s[i];
      val[4*i + 1] = u[i];
      val[4*i + 2] = -f[i];
    end
    val[12] = to_q16(-(s[0] * eye[0] + s[1] * eye[1] + s[2] * eye[2]));
    val[13] = to_q16(-(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]));
    val[14] = to_q16(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]);
    val[15] = 65536;
    for (int i = 0; i < 16; i++) begin
      e.index      = 4'(i);
      e.value      = clamp_q16(val[i]);
      e.degenerate = !(ok_f && ok_s);
      e.last       = (i == 15);
      expected_elements.push_back(e);
    end
  endtask

  task automatic send_view(input logic [31:0] eye[3], input logic [31:0] tgt[3],
                           input logic [31:0] up[3]);
    logic [287:0] item;
    for (int i = 0; i < 3; i++) begin
      item[32*i +: 32]     = eye[i];
      item[32*(3+i) +: 32] = tgt[i];
      item[32*(6+i) +: 32] = up[i];
    end
    while (!no_idle && $urandom_range(99) < stall_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_view_matrix(item);
    matrices_sent++;
  endtask

  function automatic logic [31:0] rand_word(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
      2: return 32'($signed($urandom_range(511)) - 256);
      default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                          : 32'h8000_0000 + $urandom_range(3);
    endcase
  endfunction

  // result side: random backpressure and field-by-field compare
  always @(posedge clk_i) begin
    element_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.index      = m_axis_tdata[3:0];
        got.value      = m_axis_tdata[35:4];
        got.degenerate = m_axis_tuser;
        got.last       = m_axis_tlast;
        elements_seen++;
        if (got.degenerate) degenerate_seen++;
        if (expected_elements.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected element: got %p", $time, got);
        end else begin
          want = expected_elements.pop_front();
          if (got.index !== want.index || got.value !== want.value ||
              got.degenerate !== want.degenerate || got.last !== want.last ||
              m_axis_tdata[39:36] !== 4'd0) begin
            mismatch_count++;
            $display("%0t element mismatch: expected %p, actual %p", $time, want, got);
          end
        end
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni && (s_axis_tvalid || expected_elements.size() != 0)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout at %0t", $time);
        $display("FAIL look_at_view_matrix");
        $finish;
      end
    end
  end

  task automatic test_basic_views();
    logic [31:0] e[3], t[3], u[3];
    // identity-like view, camera at origin looking down -z
    e = '{0, 0, 0}; t = '{0, 0, 32'hffff_0000}; u = '{0, 32'h0001_0000, 0};
    send_view(e, t, u);
    e = '{32'h0003_0000, 32'h0002_0000, 32'h0005_0000}; t = '{0, 0, 0};
    send_view(e, t, u);
    e = '{32'hfff0_8000, 32'h0001_2345, 32'h0000_0001}; t = '{32'h0010_0000, 0, 0};
    u = '{0, 0, 32'h0001_0000};
    send_view(e, t, u);
    // tiny direction, minimum nonzero length
    e = '{0, 0, 0}; t = '{32'h0000_0001, 0, 0}; u = '{0, 32'h0000_0001, 0};
    send_view(e, t, u);
  endtask

  task automatic test_degenerate();
    logic [31:0] e[3], t[3], u[3];
    // target equals eye
    e = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000}; t = e;
    u = '{0, 32'h0001_0000, 0};
    send_view(e, t, u);
    // up parallel to view direction
    e = '{0, 0, 0}; t = '{0, 32'h0004_0000, 0}; u = '{0, 32'h0002_0000, 0};
    send_view(e, t, u);
    // up zero
    t = '{32'h0001_0000, 0, 0}; u = '{0, 0, 0};
    send_view(e, t, u);
    // both zero
    send_view(e, e, u);
  endtask

  task automatic test_extremes();
    logic [31:0] e[3], t[3], u[3];
    // widest difference and saturating translations
    e = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    t = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    u = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000};
    send_view(e, t, u);
    send_view(t, e, u);
    e = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    t = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    u = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
    send_view(e, t, u);
    e = '{32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa};
    t = '{32'h0000_0000, 32'haaaa_aaaa, 32'h5555_5555};
    u = '{32'h0000_0001, 32'hffff_ffff, 32'h8000_0001};
    send_view(e, t, u);
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 3; i++) begin
        e[i] = rand_word(3); t[i] = rand_word(3); u[i] = rand_word(3);
      end
      send_view(e, t, u);
    end
  endtask

  task automatic test_random_views(input int unsigned count);
    logic [31:0] e[3], t[3], u[3];
    int mode;
    for (int unsigned n = 0; n < count; n++) begin
      no_idle = (n >= count / 2) && (n < count / 2 + 60);
      mode = $urandom_range(3);
      for (int i = 0; i < 3; i++) begin
        e[i] = rand_word(mode); t[i] = rand_word(mode); u[i] = rand_word(mode);
      end
      case ($urandom_range(19))
        0: t = e;
        1: for (int i = 0; i < 3; i++) u[i] = t[i] - e[i];
        2: u = '{0, 0, 0};
        default: ;
      endcase
      send_view(e, t, u);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_views();
    test_degenerate();
    test_extremes();
    test_random_views(480);
    s_axis_tvalid <= 1'b0;
    while (expected_elements.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("sent %0d view setups, checked %0d matrix elements", matrices_sent, elements_seen);
    $display("%0d elements carried the degenerate flag", degenerate_seen);
    if (mismatch_count == 0 && expected_elements.size() == 0) begin
      $display("PASS look_at_view_matrix");
    end else begin
      $display("FAIL look_at_view_matrix");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lav_pkg.sv
hw/rtl/lav_norm.sv
hw/rtl/lav_cross.sv
hw/rtl/lav_mac.sv
hw/rtl/lav_emit.sv
hw/rtl/look_at_view_matrix.sv
tb/tb.sv
